/* hdl/joystick_dead_zone_filter_assert.svh */
// Assertion macros for the joystick dead zone filter.
// Needs clk_i and rst_ni in the including module; no other dependencies.
`ifndef JOYSTICK_DEAD_ZONE_FILTER_ASSERT_SVH
`define JOYSTICK_DEAD_ZONE_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JDZF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JDZF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/jdzf_pkg.sv */
// Package of the joystick dead zone filter: sizes, request codes, stage map and side data.
// No dependencies.
`default_nettype none

package jdzf_pkg;

  localparam int unsigned NUM_AXES    = 6;
  localparam int unsigned NUM_REGS    = 6;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned DZ_W        = 15;
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd5571;

  // Stage map of the pipeline
  localparam int unsigned ST_SQ_FIRST = 3;
  localparam int unsigned ST_SQ_LAST  = 26;
  localparam int unsigned ST_G0       = 27;
  localparam int unsigned ST_G_LAST   = 51;
  localparam int unsigned ST_MUL      = 52;
  localparam int unsigned ST_NUM      = 53;
  localparam int unsigned ST_Q0       = 54;
  localparam int unsigned ST_Q_LAST   = 69;
  localparam int unsigned ST_OUT      = 70;

  typedef enum logic [1:0] {
    REQ_SINGLE = 2'd0,
    REQ_RADIAL = 2'd1,
    REQ_CROSS  = 2'd2,
    REQ_BOWTIE = 2'd3
  } req_e;

  typedef struct packed {
    req_e             typ;
    logic             nx;
    logic             ny;
    logic [15:0]      mx;
    logic [15:0]      my;
    logic [DZ_W-1:0]  dx;
    logic [15:0]      dd;      // 32768 - dx
    logic             keep_x;  // |x| >= dx
    logic             keep_y;  // |y| >= dy
  } side_t;

endpackage

`default_nettype wire

/* hdl/joystick_dead_zone_filter.sv */
// Channel     | Signals                                              | Handshake
// command     | req_type_i, axis_x/y_index_i, x_value_i, y_value_i  | start && !busy
// result      | x_out_o, y_out_o, saturated_o                        | done_o, one cycle
// config      | cfg_idx_i, cfg_data_i                                | cfg_we_i
//
// One transaction enters each cycle; busy is always low. A result appears on the
// outputs once its transaction has passed the same path in every mode: the 24-step
// square root, the 24-step gain divider and the 15-step output divider.
// Reset clears valid bits and loads every dead zone with 0.17.
// The receiver cannot stall; no transaction is dropped or repeated.
// Depends on jdzf_pkg and joystick_dead_zone_filter_assert.svh.
`default_nettype none

`include "joystick_dead_zone_filter_assert.svh"

module joystick_dead_zone_filter import jdzf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [DZ_W-1:0]        cfg_data_i,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type_i,
  input  logic [2:0]             axis_x_index_i,
  input  logic [2:0]             axis_y_index_i,
  input  logic signed [15:0]     x_value_i,
  input  logic signed [15:0]     y_value_i,
  output logic                   done_o,
  output logic signed [15:0]     x_out_o,
  output logic signed [15:0]     y_out_o,
  output logic                   saturated_o
);

  logic [DZ_W-1:0] dz_q [NUM_REGS];

  logic            vld_q  [0:ST_OUT];
  side_t           side_q [0:ST_Q_LAST];
  side_t           side_d;
  logic [DZ_W-1:0] dy_q;
  logic            by_q   [2:ST_Q_LAST];
  logic            rk_q   [ST_G0:ST_Q_LAST];
  logic            by_d, rk_d;

  logic [31:0] sqx_q, sqy_q, l2_q;
  logic [30:0] bp_q;

  logic [47:0] sn_q [ST_SQ_FIRST:ST_SQ_LAST], sn_d [ST_SQ_FIRST:ST_SQ_LAST];
  logic [23:0] sq_q [ST_SQ_FIRST:ST_SQ_LAST], sq_d [ST_SQ_FIRST:ST_SQ_LAST];
  logic [25:0] sr_q [ST_SQ_FIRST:ST_SQ_LAST], sr_d [ST_SQ_FIRST:ST_SQ_LAST];

  logic [23:0] gr_q [ST_G0:ST_G_LAST], gr_d [ST_G0:ST_G_LAST];
  logic [23:0] gq_q [ST_G0:ST_G_LAST], gq_d [ST_G0:ST_G_LAST];
  logic [23:0] gl_q [ST_G0:ST_G_LAST], gl_d [ST_G0:ST_G_LAST];

  logic [39:0] mg_q  [2];
  logic [31:0] num_q [2], num_d [2];

  logic [15:0] qr_q [2][ST_Q0:ST_Q_LAST], qr_d [2][ST_Q0:ST_Q_LAST];
  logic [14:0] ql_q [2][ST_Q0:ST_Q_LAST], ql_d [2][ST_Q0:ST_Q_LAST];
  logic [14:0] qq_q [2][ST_Q0:ST_Q_LAST], qq_d [2][ST_Q0:ST_Q_LAST];
  logic        ov_q [2][ST_Q0:ST_Q_LAST], ov_d [2][ST_Q0:ST_Q_LAST];

  logic [15:0]        mag_x, mag_y;
  logic signed [15:0] x_out_d, y_out_d;
  logic               sat_d;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  function automatic logic [DZ_W-1:0] zone(input logic [2:0] idx,
                                           input logic [DZ_W-1:0] regs [NUM_REGS]);
    logic [DZ_W-1:0] z;
    z = '0;
    if (32'(idx) < NUM_AXES) begin
      z = regs[idx];
    end
    return z;
  endfunction

  function automatic logic [15:0] magnitude(input logic [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  // Clip a magnitude to full scale and apply the sign.
  function automatic logic [16:0] pack(input logic [15:0] m, input logic neg);
    logic [15:0] c;
    logic        s;
    s = m[15];
    c = s ? 16'h7fff : m;
    return {s, neg ? 16'(-c) : c};
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) dz_q[i] <= DZ_RESET;
    end else if (cfg_we_i && 32'(cfg_idx_i) < NUM_REGS) begin
      dz_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= ST_OUT; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int s = 1; s <= ST_OUT; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Input stage: split samples, look up zones
  always_comb begin
    logic [DZ_W-1:0] dx, dy;
    dx = zone(axis_x_index_i, dz_q);
    dy = zone(axis_y_index_i, dz_q);
    side_d.typ    = req_e'(req_type_i);
    side_d.nx     = x_value_i[15];
    side_d.ny     = y_value_i[15];
    side_d.mx     = magnitude(x_value_i);
    side_d.my     = magnitude(y_value_i);
    side_d.dx     = dx;
    side_d.dd     = 16'h8000 - {1'b0, dx};
    side_d.keep_x = side_d.mx >= {1'b0, dx};
    side_d.keep_y = side_d.my >= {1'b0, dy};
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    dy_q      <= zone(axis_y_index_i, dz_q);
    for (int s = 1; s <= ST_Q_LAST; s++) side_q[s] <= side_q[s-1];
    // squares and the bowtie product
    sqx_q <= side_q[0].mx * side_q[0].mx;
    sqy_q <= side_q[0].my * side_q[0].my;
    bp_q  <= side_q[0].mx * dy_q;
    l2_q  <= sqx_q + sqy_q;
    by_q[2] <= by_d;
    for (int s = 3; s <= ST_Q_LAST; s++) by_q[s] <= by_q[s-1];
    rk_q[ST_G0] <= rk_d;
    for (int s = ST_G0 + 1; s <= ST_Q_LAST; s++) rk_q[s] <= rk_q[s-1];
  end

  assign by_d = {side_q[1].my, 15'h0} >= bp_q ? 1'b1 : 1'b0;

  // Square root, one root bit per stage
  always_comb begin
    logic [47:0] n_in;
    logic [23:0] q_in;
    logic [25:0] r_in;
    logic [27:0] r2, trial;
    for (int s = ST_SQ_FIRST; s <= ST_SQ_LAST; s++) begin
      if (s == ST_SQ_FIRST) begin
        n_in = {l2_q, 16'h0};
        q_in = '0;
        r_in = '0;
      end else begin
        n_in = sn_q[s-1];
        q_in = sq_q[s-1];
        r_in = sr_q[s-1];
      end
      r2       = {r_in, n_in[47:46]};
      trial    = {2'b00, q_in, 2'b01};
      sn_d[s]  = {n_in[45:0], 2'b00};
      if (r2 >= trial) begin
        sr_d[s] = 26'(r2 - trial);
        sq_d[s] = {q_in[22:0], 1'b1};
      end else begin
        sr_d[s] = r2[25:0];
        sq_d[s] = {q_in[22:0], 1'b0};
      end
    end
  end

  // Gain g = ((L - T) << 24) / L, one quotient bit per stage
  always_comb begin
    logic [23:0] lq;
    logic [22:0] t;
    logic [24:0] rs;
    lq = sq_q[ST_SQ_LAST];
    t  = {side_q[ST_SQ_LAST].dx, 8'h00};
    rk_d = (lq != '0) && (lq >= {1'b0, t});
    gr_d[ST_G0] = lq - {1'b0, t};
    gq_d[ST_G0] = '0;
    gl_d[ST_G0] = lq;
    for (int s = ST_G0 + 1; s <= ST_G_LAST; s++) begin
      rs      = {gr_q[s-1], 1'b0};
      gl_d[s] = gl_q[s-1];
      if (rs >= {1'b0, gl_q[s-1]}) begin
        gr_d[s] = 24'(rs - {1'b0, gl_q[s-1]});
        gq_d[s] = {gq_q[s-1][22:0], 1'b1};
      end else begin
        gr_d[s] = rs[23:0];
        gq_d[s] = {gq_q[s-1][22:0], 1'b0};
      end
    end
  end

  // Output dividers: numerator select, overflow check, one quotient bit per stage
  always_comb begin
    side_t       sn, sq0;
    logic [40:0] rad;
    logic [16:0] rs;
    logic [15:0] diff;
    sn  = side_q[ST_MUL];
    sq0 = side_q[ST_NUM];
    diff = sn.mx - {1'b0, sn.dx};
    for (int ln = 0; ln < 2; ln++) begin
      rad = (41'(mg_q[ln]) + 41'({sn.dd, 8'h00})) >> 9;
      if (sn.typ == REQ_SINGLE) begin
        num_d[ln] = 32'({diff, 15'h0}) + 32'(sn.dd[15:1]);
      end else begin
        num_d[ln] = rad[31:0];
      end
      ov_d[ln][ST_Q0] = num_q[ln] >= {1'b0, sq0.dd, 15'h0};
      qr_d[ln][ST_Q0] = num_q[ln][30:15];
      ql_d[ln][ST_Q0] = num_q[ln][14:0];
      qq_d[ln][ST_Q0] = '0;
      for (int s = ST_Q0 + 1; s <= ST_Q_LAST; s++) begin
        rs = {qr_q[ln][s-1], ql_q[ln][s-1][14]};
        ov_d[ln][s] = ov_q[ln][s-1];
        ql_d[ln][s] = {ql_q[ln][s-1][13:0], 1'b0};
        if (rs >= {1'b0, side_q[s-1].dd}) begin
          qr_d[ln][s] = 16'(rs - {1'b0, side_q[s-1].dd});
          qq_d[ln][s] = {qq_q[ln][s-1][13:0], 1'b1};
        end else begin
          qr_d[ln][s] = rs[15:0];
          qq_d[ln][s] = {qq_q[ln][s-1][13:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sn_q <= sn_d;
    sq_q <= sq_d;
    sr_q <= sr_d;
    gr_q <= gr_d;
    gq_q <= gq_d;
    gl_q <= gl_d;
    mg_q[0] <= side_q[ST_G_LAST].mx * gq_q[ST_G_LAST];
    mg_q[1] <= side_q[ST_G_LAST].my * gq_q[ST_G_LAST];
    num_q <= num_d;
    qr_q  <= qr_d;
    ql_q  <= ql_d;
    qq_q  <= qq_d;
    ov_q  <= ov_d;
  end

  // Assemble the result per mode
  always_comb begin
    side_t       sf;
    logic [15:0] dx_mag, dy_mag;
    logic [16:0] px, py;
    sf     = side_q[ST_Q_LAST];
    dx_mag = ov_q[0][ST_Q_LAST] ? 16'h8000 : {1'b0, qq_q[0][ST_Q_LAST]};
    dy_mag = ov_q[1][ST_Q_LAST] ? 16'h8000 : {1'b0, qq_q[1][ST_Q_LAST]};
    unique case (sf.typ)
      REQ_SINGLE: begin
        mag_x = sf.keep_x ? dx_mag : '0;
        mag_y = '0;
      end
      REQ_RADIAL: begin
        mag_x = rk_q[ST_Q_LAST] ? dx_mag : '0;
        mag_y = rk_q[ST_Q_LAST] ? dy_mag : '0;
      end
      REQ_CROSS: begin
        mag_x = sf.keep_x ? sf.mx : '0;
        mag_y = sf.keep_y ? sf.my : '0;
      end
      REQ_BOWTIE: begin
        mag_x = sf.mx;
        mag_y = by_q[ST_Q_LAST] ? sf.my : '0;
      end
      default: begin
        mag_x = '0;
        mag_y = '0;
      end
    endcase
    px      = pack(mag_x, sf.nx);
    py      = pack(mag_y, sf.ny);
    x_out_d = px[15:0];
    y_out_d = py[15:0];
    sat_d   = px[16] | py[16];
  end

  always_ff @(posedge clk_i) begin
    x_out_o     <= x_out_d;
    y_out_o     <= y_out_d;
    saturated_o <= sat_d;
  end

  assign done_o = vld_q[ST_OUT];

  `JDZF_ASSERT_NOW(a_no_min_neg, done_o, x_out_o != 16'sh8000 && y_out_o != 16'sh8000, "most negative value on output")
  `JDZF_ASSERT_NOW(a_sat_full_scale, done_o && saturated_o, x_out_o == 16'sh7fff || x_out_o == -16'sh7fff || y_out_o == 16'sh7fff || y_out_o == -16'sh7fff, "saturated without full scale output")
  `JDZF_ASSERT_NEXT(a_single_y_zero, vld_q[ST_Q_LAST] && side_q[ST_Q_LAST].typ == REQ_SINGLE, y_out_o == 16'sh0000, "single mode y not zero")
  `JDZF_ASSERT_NEXT(a_radial_zone, vld_q[ST_Q_LAST] && side_q[ST_Q_LAST].typ == REQ_RADIAL && !rk_q[ST_Q_LAST], x_out_o == 16'sh0000 && y_out_o == 16'sh0000 && !saturated_o, "radial pair inside zone not zero")

endmodule

`default_nettype wire
